// ===== rtl/core/tle_pkg.sv =====
package tle_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;

    localparam int GRAY_W      = 8;
    localparam int EDGE_W      = 8;
    localparam int COL_OUT_W   = 10;
    localparam int ROW_OUT_W   = 10;
    localparam int THRESHOLD_W = 8;
    localparam int WIDTH_W     = 11;
    localparam int HEIGHT_W    = 11;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 8'd88;
    localparam logic [WIDTH_W-1:0]     WIDTH_RST     = 11'd950;
    localparam logic [HEIGHT_W-1:0]    HEIGHT_RST    = 11'd950;

    localparam logic [EDGE_W-1:0] WHITE_LEVEL = 8'd255;
    localparam logic [EDGE_W-1:0] BLACK_LEVEL = 8'd0;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // line store word: one bit of the row above, one of the centre row
    localparam int LINE_W     = 2;
    localparam int UPPER_BIT  = 1;
    localparam int CENTRE_BIT = 0;

    typedef enum logic [1:0] {
        REG_THRESHOLD,
        REG_IMAGE_WIDTH,
        REG_IMAGE_HEIGHT
    } cfg_index_t;

    typedef struct packed {
        logic [THRESHOLD_W-1:0] threshold;
        logic [WIDTH_W-1:0]     image_width;
        logic [HEIGHT_W-1:0]    image_height;
    } tle_cfg_t;

endpackage

// ===== rtl/core/tle_pixel_if.sv =====
interface tle_pixel_if import tle_pkg::*; ();

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [GRAY_W-1:0] gray_value;

    modport source (output valid, output opcode, output gray_value, input ready);
    modport sink (input valid, input opcode, input gray_value, output ready);

endinterface

// ===== rtl/core/tle_result_if.sv =====
interface tle_result_if import tle_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [EDGE_W-1:0]    edge_value;
    logic [COL_OUT_W-1:0] pixel_col;
    logic [ROW_OUT_W-1:0] pixel_row;
    logic                 frame_end;

    modport source (
        output valid, output edge_value, output pixel_col, output pixel_row,
        output frame_end, input ready
    );
    modport sink (
        input valid, input edge_value, input pixel_col, input pixel_row,
        input frame_end, output ready
    );

endinterface

// ===== rtl/core/threshold_laplacian_edge_unit.sv =====
// a request is held in the stage register, then its result in the output register
// one request per cycle unless stalled, set by the two-port line store read and its write-back
// results trail the input by one row; flush requests drain the final row
// reset: asynchronous, active low; config returns to threshold 88 and 950 x 950
// after reset the line store is cleared one entry a cycle, all MAX_WIDTH entries, with input held off
module threshold_laplacian_edge_unit
    import tle_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    tle_pixel_if.sink         pixel,
    tle_result_if.source      result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;

    typedef struct packed {
        logic [CW-1:0]        col;
        logic [ROW_OUT_W-1:0] row;
        logic                 emit;
        logic                 flushing;
        logic                 newbit;
        logic                 has_up;
        logic                 has_left;
        logic                 has_right;
        logic                 frame_end;
        logic                 hit_a;
        logic                 hit_b;
    } stage_t;

    tle_cfg_t cfg;

    tle_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [CW-1:0]       col_reg, col_next;
    logic [HEIGHT_W-1:0] row_reg, row_next;
    logic                clearing_reg;
    logic [CW-1:0]       clr_cnt_reg;
    logic                stage_valid_reg, stage_valid_next;
    stage_t              stage_reg, stage_next;
    logic [LINE_W-1:0]   wr_last_reg;
    logic                left_reg;
    logic                res_valid_reg;

    logic [EW-1:0]       eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic                out_of_frame;
    logic [CW-1:0]       cur_col;
    logic [HEIGHT_W-1:0] cur_row;
    logic [EW-1:0]       col_plus;
    logic                flushing;
    logic                skip;
    logic                accept;
    logic                proc;
    logic                newbit;
    logic                last_col;
    logic [CW-1:0]       rd_a_addr, rd_b_addr;
    logic [LINE_W-1:0]   rd_a_data, rd_b_data;

    logic                ctr, up, right, all_white;
    logic [EDGE_W-1:0]   edge_val;
    logic                stage_go, stage_adv;
    logic                ram_we;
    logic [CW-1:0]       ram_waddr;
    logic [LINE_W-1:0]   ram_wdata;

    // frame geometry
    always_comb
    begin
        eff_w = EW'(cfg.image_width);
        if (cfg.image_width == '0)
        begin
            eff_w = EW'(1);
        end
        else if (eff_w > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        eff_h = cfg.image_height;
        if (cfg.image_height == '0)
        begin
            eff_h = HEIGHT_W'(1);
        end
        else if (cfg.image_height > HEIGHT_W'(MAX_HEIGHT))
        begin
            eff_h = HEIGHT_W'(MAX_HEIGHT);
        end
    end

    // front: position of the incoming request and line store read
    assign out_of_frame = (row_reg > eff_h) || (EW'(col_reg) >= eff_w);
    assign cur_col      = out_of_frame ? '0 : col_reg;
    assign cur_row      = out_of_frame ? '0 : row_reg;
    assign flushing     = (cur_row == eff_h);
    assign skip         = !flushing && (pixel.opcode == OP_FLUSH);
    assign col_plus     = EW'(cur_col) + EW'(1);
    assign last_col     = (col_plus >= eff_w);
    assign newbit       = !flushing && (pixel.gray_value > cfg.threshold);

    assign stage_go   = !stage_reg.emit || !res_valid_reg || result.ready;
    assign stage_adv  = stage_valid_reg && stage_go;
    assign pixel.ready = !clearing_reg && (!stage_valid_reg || stage_go);
    assign accept     = pixel.valid && pixel.ready;
    assign proc       = accept && !skip;

    assign rd_a_addr = cur_col;
    assign rd_b_addr = (cur_col == CW'(MAX_WIDTH - 1)) ? '0 : cur_col + CW'(1);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            col_next = cur_col;
            row_next = cur_row;
            if (!skip)
            begin
                if (last_col)
                begin
                    col_next = '0;
                    row_next = flushing ? '0 : cur_row + HEIGHT_W'(1);
                end
                else
                begin
                    col_next = cur_col + CW'(1);
                end
            end
        end
    end

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_next       = stage_reg;
        if (stage_adv)
        begin
            stage_valid_next = 1'b0;
        end
        if (proc)
        begin
            stage_valid_next     = 1'b1;
            stage_next.col       = cur_col;
            stage_next.row       = ROW_OUT_W'(cur_row - HEIGHT_W'(1));
            stage_next.emit      = (cur_row != '0);
            stage_next.flushing  = flushing;
            stage_next.newbit    = newbit;
            stage_next.has_up    = (cur_row > HEIGHT_W'(1));
            stage_next.has_left  = (cur_col != '0);
            stage_next.has_right = !last_col;
            stage_next.frame_end = flushing && last_col;
            // write-back of the request ahead lands on the same edge as this read
            stage_next.hit_a     = stage_adv && (stage_reg.col == rd_a_addr);
            stage_next.hit_b     = stage_adv && (stage_reg.col == rd_b_addr);
        end
    end

    // back: neighborhood, result and write-back
    assign ctr   = stage_reg.hit_a ? wr_last_reg[CENTRE_BIT] : rd_a_data[CENTRE_BIT];
    assign up    = stage_reg.hit_a ? wr_last_reg[UPPER_BIT]  : rd_a_data[UPPER_BIT];
    assign right = stage_reg.hit_b ? wr_last_reg[CENTRE_BIT] : rd_b_data[CENTRE_BIT];

    assign all_white = (stage_reg.has_up && up) && (stage_reg.has_left && left_reg)
                     && (stage_reg.has_right && right)
                     && (!stage_reg.flushing && stage_reg.newbit);
    assign edge_val  = (ctr && !all_white) ? WHITE_LEVEL : BLACK_LEVEL;

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = stage_adv;
            ram_waddr = stage_reg.col;
            ram_wdata = {ctr, stage_reg.newbit};
        end
    end

    tle_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (proc),
        .raddr_a (rd_a_addr),
        .raddr_b (rd_b_addr),
        .rdata_a (rd_a_data),
        .rdata_b (rd_b_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            clearing_reg    <= 1'b1;
            clr_cnt_reg     <= '0;
            stage_valid_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            stage_valid_reg <= stage_valid_next;
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(MAX_WIDTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (stage_adv && stage_reg.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
        if (stage_adv)
        begin
            wr_last_reg <= {ctr, stage_reg.newbit};
            left_reg    <= ctr;
        end
        if (stage_adv && stage_reg.emit)
        begin
            result.edge_value <= edge_val;
            result.pixel_col  <= COL_OUT_W'(stage_reg.col);
            result.pixel_row  <= stage_reg.row;
            result.frame_end  <= stage_reg.frame_end;
        end
    end

    assign result.valid = res_valid_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !pixel.ready)
        else $error("request taken during line store clear");

    a_forward_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && stage_adv && (stage_reg.col == rd_a_addr)) |=> stage_reg.hit_a)
        else $error("same-entry write-back not forwarded");

    a_stalled_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_go) |=> (stage_valid_reg && $stable(stage_reg)))
        else $error("stalled stage lost its request");

    a_binary_edge: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.edge_value == WHITE_LEVEL || result.edge_value == BLACK_LEVEL))
        else $error("edge value not black or white");

endmodule

// ===== rtl/core/tle_ram.sv =====
module tle_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ===== rtl/core/tle_cfg_regs.sv =====
module tle_cfg_regs
    import tle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready,
    output tle_cfg_t          cfg
);

    tle_cfg_t   cfg_reg;
    cfg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = cfg_index_t'(paddr[CFG_AW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= THRESHOLD_RST;
            cfg_reg.image_width  <= WIDTH_RST;
            cfg_reg.image_height <= HEIGHT_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_THRESHOLD:    cfg_reg.threshold    <= pwdata[THRESHOLD_W-1:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= pwdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= pwdata[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_THRESHOLD:    prdata = CFG_DW'(cfg_reg.threshold);
            REG_IMAGE_WIDTH:  prdata = CFG_DW'(cfg_reg.image_width);
            REG_IMAGE_HEIGHT: prdata = CFG_DW'(cfg_reg.image_height);
            default:          prdata = '0;
        endcase
    end

endmodule
